@@ design/route_discovery_table_core_macros.svh @@
// Assertion macros used by the route discovery table checker.
`ifndef ROUTE_DISCOVERY_TABLE_CORE_MACROS_SVH
`define ROUTE_DISCOVERY_TABLE_CORE_MACROS_SVH

// Check a property at every rising edge, including edges in reset.
`define RDT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Check a property at every rising edge outside reset.
`define RDT_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

@@ design/rdt_pkg.sv @@
// Types and constants of the route discovery table.
`default_nettype none
package rdt_pkg;

   localparam int RDT_DEPTH = 16;
   localparam int ADDR_W    = 16;
   localparam int ID_W      = 8;
   localparam int COST_W    = 8;
   localparam int TIME_W    = 16;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   localparam logic [COST_W-1:0] RESIDUAL_COST_FIXED = 8'hff;
   localparam logic [TIME_W-1:0] LIFETIME_RESET      = 16'd10000;
   localparam logic [TIME_W-1:0] STEP_RESET          = 16'd1000;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_TICK   = 2'd3
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIFETIME = 1'b0,
      CSR_STEP     = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_SETTLE,
      CELL_CLEAR
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_SETTLE
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   request;
      logic [ADDR_W-1:0] source;
      logic [ADDR_W-1:0] sender;
      logic [ADDR_W-1:0] target;
      logic [COST_W-1:0] cost;
      logic [TIME_W-1:0] time_left;
   } entry_type;

endpackage
`default_nettype wire

@@ design/rdt_cell.sv @@
// One table cell: holds one entry and trades it with its neighbors.
`default_nettype none
module rdt_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire rdt_pkg::cell_op_type op,
   input  wire                       left_valid,
   input  wire rdt_pkg::entry_type   right_entry,
   output rdt_pkg::entry_type        entry
);
   import rdt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (op)
         CELL_SHIFT: begin
            entry_in = right_entry;
         end
         CELL_SETTLE: begin
            // fill a hole from the right; hand own entry to an empty left cell
            if (!entry_ff.valid) begin
               entry_in = right_entry;
            end else if (!left_valid) begin
               entry_in.valid = 1'b0;
            end
         end
         CELL_CLEAR: begin
            entry_in.valid = 1'b0;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
      if (reset) begin
         entry_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

@@ design/route_discovery_table_core.sv @@
// Top level of the route discovery table: cell chain, head unit and sequencer.
`default_nettype none
// Route discovery table. Entries sit packed, oldest first, in a chain of DEPTH
// cells. A command is accepted when start is high and busy is low; every
// result appears on the rsp_ ports for exactly one cycle with rsp_valid high,
// and the receiver cannot stall it, so take each one when it shows. Clear and
// insert answer in the cycle after acceptance; clear leaves busy low, and
// insert keeps busy high while the new entry drops from the tail cell into
// place (not at all when the table is full). Lookup and tick rotate the
// whole chain once through the head cell, one cell per cycle; lookup then
// answers, while tick reports each freed entry as it passes the head
// (expired high, last low) and afterwards closes the holes it left, one
// position per cycle, before its final transaction with ok and last high.
// Configuration writes take effect at once and belong between commands.
module route_discovery_table_core #(
   parameter int DEPTH = rdt_pkg::RDT_DEPTH
) (
   input  wire                           clock,
   input  wire                           reset,
   // command transaction
   input  wire                           start,
   output logic                          busy,
   input  wire  [rdt_pkg::CMD_W-1:0]     req_command,
   input  wire  [rdt_pkg::ID_W-1:0]      req_request_id,
   input  wire  [rdt_pkg::ADDR_W-1:0]    req_source_addr,
   input  wire  [rdt_pkg::ADDR_W-1:0]    req_prev_hop,
   input  wire  [rdt_pkg::ADDR_W-1:0]    req_destination,
   input  wire  [rdt_pkg::COST_W-1:0]    req_path_cost,
   // result transaction
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic                          rsp_expired,
   output logic [rdt_pkg::ADDR_W-1:0]    rsp_hop_addr,
   output logic [rdt_pkg::ADDR_W-1:0]    rsp_target_addr,
   output logic [rdt_pkg::COST_W-1:0]    rsp_forward_cost,
   output logic [rdt_pkg::COST_W-1:0]    rsp_residual_cost,
   output logic [rdt_pkg::TIME_W-1:0]    rsp_time_left,
   output logic                          rsp_last,
   // configuration writes
   input  wire                           csr_we,
   input  wire  [rdt_pkg::CSR_IDX_W-1:0] csr_addr,
   input  wire  [rdt_pkg::CSR_W-1:0]     csr_wdata
);
   import rdt_pkg::*;

   localparam int CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration
   logic [TIME_W-1:0] lifetime_ff;
   logic [TIME_W-1:0] step_ff;

   // sequencer
   state_type        state_ff, state_in;
   command_type      cmd_ff, cmd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             found_ff, found_in;
   entry_type        hit_ff, hit_in;
   entry_type        pend_ff, pend_in;
   logic [ID_W-1:0]   key_req_ff, key_req_in;
   logic [ADDR_W-1:0] key_src_ff, key_src_in;
   cell_op_type      cell_op;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_expired_ff, rsp_expired_in;
   logic [ADDR_W-1:0] rsp_hop_ff, rsp_hop_in;
   logic [ADDR_W-1:0] rsp_target_ff, rsp_target_in;
   logic [COST_W-1:0] rsp_fcost_ff, rsp_fcost_in;
   logic [COST_W-1:0] rsp_rcost_ff, rsp_rcost_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic              rsp_last_ff, rsp_last_in;

   // chain
   entry_type        cell_entry [DEPTH];
   entry_type        tail_feed;
   entry_type        head, head_next;
   logic             head_free;
   logic             head_match;
   logic [DEPTH-1:0] hole;
   logic             any_hole;
   logic             accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // ---------------------------------------------------------------- cells
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic      left_valid;
         entry_type right_entry;
         if (gi == 0) begin : g_first
            assign left_valid = 1'b1;
         end else begin : g_inner
            assign left_valid = cell_entry[gi-1].valid;
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign right_entry = tail_feed;
            assign hole[gi]    = 1'b0;
         end else begin : g_body
            assign right_entry = cell_entry[gi+1];
            // an empty cell with a filled one to its right still has to settle
            assign hole[gi]    = !cell_entry[gi].valid && cell_entry[gi+1].valid;
         end
         rdt_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (cell_op),
            .left_valid  (left_valid),
            .right_entry (right_entry),
            .entry       (cell_entry[gi])
         );
      end
   endgenerate

   assign any_hole = |hole;

   // ---------------------------------------------------------------- head unit
   // The head cell's entry is worked on as it leaves for the tail.
   assign head       = cell_entry[0];
   assign head_free  = head.valid && (head.time_left == '0);
   assign head_match = head.valid && (head.request == key_req_ff)
                       && (head.source == key_src_ff);

   always_comb begin
      head_next = head;
      if (cmd_ff == CMD_TICK) begin
         // drop a spent entry, age the rest with saturation at zero
         head_next.valid     = head.valid && !head_free;
         head_next.time_left = (head.time_left > step_ff) ?
                               (head.time_left - step_ff) : '0;
      end
   end

   // rotate the head back in at the tail; otherwise feed the pending insert
   assign tail_feed = (state_ff == ST_ROTATE) ? head_next : pend_ff;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      pend_in    = pend_ff;
      key_req_in = key_req_ff;
      key_src_in = key_src_ff;
      cell_op    = CELL_HOLD;

      rsp_valid_in   = 1'b0;
      rsp_ok_in      = 1'b0;
      rsp_expired_in = 1'b0;
      rsp_hop_in     = '0;
      rsp_target_in  = '0;
      rsp_fcost_in   = '0;
      rsp_rcost_in   = '0;
      rsp_time_in    = '0;
      rsp_last_in    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = command_type'(req_command);
               key_req_in = req_request_id;
               key_src_in = req_source_addr;
               count_in   = '0;
               found_in   = 1'b0;
               case (command_type'(req_command))
                  CMD_CLEAR: begin
                     cell_op      = CELL_CLEAR;
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
                  CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     // table is packed, so a filled tail cell means full
                     if (!cell_entry[DEPTH-1].valid) begin
                        rsp_ok_in         = 1'b1;
                        pend_in.valid     = 1'b1;
                        pend_in.request   = req_request_id;
                        pend_in.source    = req_source_addr;
                        pend_in.sender    = req_prev_hop;
                        pend_in.target    = req_destination;
                        pend_in.cost      = req_path_cost;
                        pend_in.time_left = lifetime_ff;
                        state_in          = ST_SETTLE;
                     end
                  end
                  CMD_LOOKUP: begin
                     state_in = ST_ROTATE;
                  end
                  CMD_TICK: begin
                     state_in = ST_ROTATE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_ROTATE: begin
            cell_op  = CELL_SHIFT;
            count_in = count_ff + CNT_W'(1);
            if (cmd_ff == CMD_LOOKUP && head_match && !found_ff) begin
               found_in = 1'b1;
               hit_in   = head;
            end
            if (cmd_ff == CMD_TICK && head_free) begin
               rsp_valid_in   = 1'b1;
               rsp_expired_in = 1'b1;
               rsp_target_in  = head.target;
            end
            if (count_ff == CNT_W'(DEPTH - 1)) begin
               if (cmd_ff == CMD_LOOKUP) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  if (found_in) begin
                     rsp_ok_in     = 1'b1;
                     rsp_hop_in    = hit_in.sender;
                     rsp_target_in = hit_in.target;
                     rsp_fcost_in  = hit_in.cost;
                     rsp_rcost_in  = RESIDUAL_COST_FIXED;
                     rsp_time_in   = hit_in.time_left;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SETTLE;
               end
            end
         end

         ST_SETTLE: begin
            cell_op       = CELL_SETTLE;
            pend_in.valid = 1'b0;
            if (!any_hole && !pend_ff.valid) begin
               state_in = ST_IDLE;
               if (cmd_ff == CMD_TICK) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_last_in  = 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold off a stale insert after reset
      if (reset) begin
         pend_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lifetime_ff  <= LIFETIME_RESET;
         step_ff      <= STEP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_LIFETIME: lifetime_ff <= csr_wdata;
               CSR_STEP:     step_ff     <= csr_wdata;
               default:      lifetime_ff <= lifetime_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      count_ff       <= count_in;
      found_ff       <= found_in;
      hit_ff         <= hit_in;
      pend_ff        <= pend_in;
      key_req_ff     <= key_req_in;
      key_src_ff     <= key_src_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_fcost_ff   <= rsp_fcost_in;
      rsp_rcost_ff   <= rsp_rcost_in;
      rsp_time_ff    <= rsp_time_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_expired       = rsp_expired_ff;
   assign rsp_hop_addr      = rsp_hop_ff;
   assign rsp_target_addr   = rsp_target_ff;
   assign rsp_forward_cost  = rsp_fcost_ff;
   assign rsp_residual_cost = rsp_rcost_ff;
   assign rsp_time_left     = rsp_time_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
`default_nettype wire

@@ design/rdt_checker.sv @@
// Port-level checks of the route discovery table, bound to the top level.
`default_nettype none
`include "route_discovery_table_core_macros.svh"
module rdt_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       start,
   input wire                       busy,
   input wire [rdt_pkg::CMD_W-1:0]  req_command,
   input wire                       rsp_valid,
   input wire                       rsp_ok,
   input wire                       rsp_expired,
   input wire                       rsp_last
);
   import rdt_pkg::*;

   logic short_cmd;
   logic expired_out;

   // clear or insert taken at this edge
   assign short_cmd   = start && !busy &&
                        (req_command == CMD_CLEAR || req_command == CMD_INSERT);
   assign expired_out = rsp_valid && rsp_expired;

   // reset leaves the block idle with no transaction on the result side
   `RDT_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy && !rsp_valid, "not idle after reset")

   // clear and insert answer with their final transaction in the next cycle
   `RDT_ASSERT_RUN(a_short_answer, short_cmd |=> rsp_valid && rsp_last, "no short answer")

   // a freed entry report is never the final transaction and never ok
   `RDT_ASSERT_RUN(a_expired_form, expired_out |-> !rsp_ok && !rsp_last, "bad expired report")

   // a tick is still running when it reports a freed entry
   `RDT_ASSERT_RUN(a_expired_busy, expired_out |-> busy, "expired report while idle")

endmodule

bind route_discovery_table_core rdt_checker u_rdt_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_ok      (rsp_ok),
   .rsp_expired (rsp_expired),
   .rsp_last    (rsp_last)
);
`default_nettype wire

@@ sim/tb_route_discovery_table_core.sv @@
// Self-checking testbench for the route discovery table core.
`timescale 1ns / 1ps

module tb_route_discovery_table_core;
   import rdt_pkg::*;

   localparam int DEPTH       = RDT_DEPTH;
   // Watchdog limit on the length of the whole run.
   localparam int CYCLE_LIMIT = 200000;
   // Covers the longest busy stretch of one command (tick: rotate plus compaction).
   localparam int SETTLE_CYCLES = 2 * DEPTH + 4;

   // One command transaction as the sender sees it.
   typedef struct packed {
      command_type       cmd;
      logic [ID_W-1:0]   request_id;
      logic [ADDR_W-1:0] source_addr;
      logic [ADDR_W-1:0] prev_hop;
      logic [ADDR_W-1:0] destination;
      logic [COST_W-1:0] path_cost;
   } route_cmd_type;

   // One result transaction; fields not meaningful for it are zero.
   typedef struct packed {
      logic              ok;
      logic              expired;
      logic [ADDR_W-1:0] hop_addr;
      logic [ADDR_W-1:0] target_addr;
      logic [COST_W-1:0] forward_cost;
      logic [COST_W-1:0] residual_cost;
      logic [TIME_W-1:0] time_left;
      logic              last;
   } route_reply_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_command = '0;
   logic [ID_W-1:0]      req_request_id = '0;
   logic [ADDR_W-1:0]    req_source_addr = '0;
   logic [ADDR_W-1:0]    req_prev_hop = '0;
   logic [ADDR_W-1:0]    req_destination = '0;
   logic [COST_W-1:0]    req_path_cost = '0;
   logic                 rsp_valid;
   logic                 rsp_ok;
   logic                 rsp_expired;
   logic [ADDR_W-1:0]    rsp_hop_addr;
   logic [ADDR_W-1:0]    rsp_target_addr;
   logic [COST_W-1:0]    rsp_forward_cost;
   logic [COST_W-1:0]    rsp_residual_cost;
   logic [TIME_W-1:0]    rsp_time_left;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   route_discovery_table_core #(.DEPTH(DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_request_id    (req_request_id),
      .req_source_addr   (req_source_addr),
      .req_prev_hop      (req_prev_hop),
      .req_destination   (req_destination),
      .req_path_cost     (req_path_cost),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_expired       (rsp_expired),
      .rsp_hop_addr      (rsp_hop_addr),
      .rsp_target_addr   (rsp_target_addr),
      .rsp_forward_cost  (rsp_forward_cost),
      .rsp_residual_cost (rsp_residual_cost),
      .rsp_time_left     (rsp_time_left),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Commands waiting for the driver, and the results still owed by the block.
   route_cmd_type   pending_cmds[$];
   route_reply_type expected_replies[$];
   route_cmd_type   cur_cmd;
   // Recently inserted {request id, source} pairs, reused for hits and duplicates.
   logic [ID_W+ADDR_W-1:0] recent_keys[$];

   logic steady = 1'b0;   // set to suppress sender idling
   int   mismatch_count = 0;
   int   cycle_count = 0;

   // Shadow copy of the table, kept packed in insertion order.
   logic [TIME_W-1:0] cfg_lifetime = LIFETIME_RESET;
   logic [TIME_W-1:0] cfg_step     = STEP_RESET;
   int                table_count  = 0;
   logic [ID_W-1:0]   tbl_request[DEPTH];
   logic [ADDR_W-1:0] tbl_source[DEPTH];
   logic [ADDR_W-1:0] tbl_sender[DEPTH];
   logic [ADDR_W-1:0] tbl_target[DEPTH];
   logic [COST_W-1:0] tbl_cost[DEPTH];
   logic [TIME_W-1:0] tbl_time[DEPTH];

   // Apply one accepted command to the shadow table and queue its results.
   task automatic predict_route_command(route_cmd_type c);
      route_reply_type r;
      int              found;
      int              keep;
      r = '0;
      case (c.cmd)
         CMD_CLEAR: begin
            table_count = 0;
            r.ok = 1'b1;
         end
         CMD_INSERT: begin
            // Full table: store nothing, answer with ok low.
            if (table_count < DEPTH) begin
               tbl_request[table_count] = c.request_id;
               tbl_source[table_count]  = c.source_addr;
               tbl_sender[table_count]  = c.prev_hop;
               tbl_target[table_count]  = c.destination;
               tbl_cost[table_count]    = c.path_cost;
               tbl_time[table_count]    = cfg_lifetime;
               table_count++;
               r.ok = 1'b1;
            end
         end
         CMD_LOOKUP: begin
            // Earliest match wins when duplicates exist.
            found = -1;
            for (int i = 0; i < table_count; i++) begin
               if (found < 0 && tbl_request[i] == c.request_id &&
                   tbl_source[i] == c.source_addr)
                  found = i;
            end
            if (found >= 0) begin
               r.ok            = 1'b1;
               r.hop_addr      = tbl_sender[found];
               r.target_addr   = tbl_target[found];
               r.forward_cost  = tbl_cost[found];
               r.residual_cost = RESIDUAL_COST_FIXED;
               r.time_left     = tbl_time[found];
            end
         end
         default: begin
            // Tick: free entries at zero in order, age the rest, close holes.
            keep = 0;
            for (int i = 0; i < table_count; i++) begin
               if (tbl_time[i] == '0) begin
                  r = '0;
                  r.expired     = 1'b1;
                  r.target_addr = tbl_target[i];
                  expected_replies.push_back(r);
               end else begin
                  tbl_request[keep] = tbl_request[i];
                  tbl_source[keep]  = tbl_source[i];
                  tbl_sender[keep]  = tbl_sender[i];
                  tbl_target[keep]  = tbl_target[i];
                  tbl_cost[keep]    = tbl_cost[i];
                  tbl_time[keep]    = (tbl_time[i] > cfg_step) ? tbl_time[i] - cfg_step : '0;
                  keep++;
               end
            end
            table_count = keep;
            r = '0;
            r.ok = 1'b1;
         end
      endcase
      r.last = 1'b1;
      expected_replies.push_back(r);
   endtask

   // Driver: present the next pending command, hold it until accepted.
   always @(posedge clock) begin : command_driver
      logic hold;
      hold = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && busy === 1'b0) begin
            // Transaction accepted at this edge: predict it now.
            predict_route_command(cur_cmd);
         end else if (start) begin
            hold = 1'b1;
         end
         if (!hold) begin
            if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= 30)) begin
               cur_cmd = pending_cmds.pop_front();
               start           <= 1'b1;
               req_command     <= cur_cmd.cmd;
               req_request_id  <= cur_cmd.request_id;
               req_source_addr <= cur_cmd.source_addr;
               req_prev_hop    <= cur_cmd.prev_hop;
               req_destination <= cur_cmd.destination;
               req_path_cost   <= cur_cmd.path_cost;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("t=%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Monitor: every strobed result is taken and matched against the oldest expectation.
   always @(posedge clock) begin : reply_monitor
      route_reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_replies.size() == 0) begin
            $display("t=%0t unexpected result: expected none, actual ok=%0b expired=%0b last=%0b",
                     $time, rsp_ok, rsp_expired, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("ok", 16'(want.ok), 16'(rsp_ok));
            check_field("expired", 16'(want.expired), 16'(rsp_expired));
            check_field("hop_addr", want.hop_addr, rsp_hop_addr);
            check_field("target_addr", want.target_addr, rsp_target_addr);
            check_field("forward_cost", 16'(want.forward_cost), 16'(rsp_forward_cost));
            check_field("residual_cost", 16'(want.residual_cost), 16'(rsp_residual_cost));
            check_field("time_left", want.time_left, rsp_time_left);
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   // Watchdog: abort a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("route_discovery_table_core regression: fail");
         $finish;
      end
   end

   task automatic queue_cmd(command_type cmd, logic [ID_W-1:0] id, logic [ADDR_W-1:0] src,
                            logic [ADDR_W-1:0] snd, logic [ADDR_W-1:0] dst,
                            logic [COST_W-1:0] cost);
      route_cmd_type c;
      c.cmd         = cmd;
      c.request_id  = id;
      c.source_addr = src;
      c.prev_hop    = snd;
      c.destination = dst;
      c.path_cost   = cost;
      pending_cmds.push_back(c);
   endtask

   // Mostly inserts and lookups on known keys so the table fills and hits;
   // ticks age and free entries; clears are rare so the full case shows up.
   task automatic queue_random_cmd();
      route_cmd_type          c;
      int                     roll;
      logic [ID_W+ADDR_W-1:0] key;
      roll          = $urandom_range(0, 99);
      c.request_id  = ID_W'($urandom);
      c.source_addr = ADDR_W'($urandom);
      c.prev_hop    = ADDR_W'($urandom);
      c.destination = ADDR_W'($urandom);
      c.path_cost   = COST_W'($urandom);
      if (roll < 4) begin
         c.cmd = CMD_CLEAR;
      end else if (roll < 45) begin
         c.cmd = CMD_INSERT;
         // Reuse a key now and then to build duplicates.
         if (recent_keys.size() != 0 && $urandom_range(0, 3) == 0) begin
            key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            {c.request_id, c.source_addr} = key;
         end
         recent_keys.push_back({c.request_id, c.source_addr});
         if (recent_keys.size() > 24)
            key = recent_keys.pop_front();
      end else if (roll < 70) begin
         c.cmd = CMD_LOOKUP;
         if (recent_keys.size() != 0 && $urandom_range(0, 3) != 0) begin
            key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            {c.request_id, c.source_addr} = key;
         end
      end else begin
         c.cmd = CMD_TICK;
      end
      pending_cmds.push_back(c);
   endtask

   // Wait until the sender is drained, nothing is owed and the block is idle,
   // then let the longest command's worth of cycles pass.
   task automatic await_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_replies.size() != 0 ||
             busy !== 1'b0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write: one cycle of write enable, shadow updated alongside.
   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LIFETIME)
         cfg_lifetime = value;
      else
         cfg_step = value;
      @(negedge clock);
   endtask

   task automatic configure(logic [TIME_W-1:0] lifetime, logic [TIME_W-1:0] step);
      await_idle();
      write_csr(CSR_LIFETIME, lifetime);
      write_csr(CSR_STEP, step);
   endtask

   task automatic run_random_phase(logic [TIME_W-1:0] lifetime, logic [TIME_W-1:0] step,
                                   int count, logic no_idle);
      configure(lifetime, step);
      steady = no_idle;
      repeat (count) queue_random_cmd();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pass at reset settings: empty table, field extremes,
      // duplicates, filling to the brim, insert when full, a plain tick.
      queue_cmd(CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_TICK,   8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_CLEAR,  8'hff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
      queue_cmd(CMD_INSERT, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_INSERT, 8'hff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
      queue_cmd(CMD_INSERT, 8'h00, 16'h0000, 16'h1234, 16'h5678, 8'h07);
      queue_cmd(CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_LOOKUP, 8'hff, 16'hffff, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_LOOKUP, 8'h00, 16'hffff, 16'h0000, 16'h0000, 8'h00);
      repeat (DEPTH - 3)
         queue_cmd(CMD_INSERT, ID_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom),
                   ADDR_W'($urandom), COST_W'($urandom));
      queue_cmd(CMD_INSERT, 8'h5a, 16'ha5a5, 16'h0f0f, 16'hf0f0, 8'h3c);
      queue_cmd(CMD_TICK,   8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_LOOKUP, 8'hff, 16'hffff, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_CLEAR,  8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);

      // Zero lifetime: fresh entries are freed by the very next tick.
      configure(16'd0, 16'hffff);
      queue_cmd(CMD_INSERT, 8'h11, 16'h2222, 16'h3333, 16'h4444, 8'h55);
      queue_cmd(CMD_INSERT, 8'h66, 16'h7777, 16'h8888, 16'h9999, 8'haa);
      queue_cmd(CMD_INSERT, 8'h11, 16'h2222, 16'hbbbb, 16'hcccc, 8'hdd);
      queue_cmd(CMD_LOOKUP, 8'h11, 16'h2222, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_TICK,   8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_cmd(CMD_TICK,   8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      repeat (50) queue_random_cmd();

      // Extremes of both registers, including a zero step that freezes
      // nonzero times, then zero-time entries mixed among frozen ones.
      run_random_phase(16'hffff, 16'd1, 50, 1'b0);
      run_random_phase(16'hffff, 16'd0, 40, 1'b0);
      run_random_phase(16'd0, 16'd0, 30, 1'b0);
      run_random_phase(16'hffff, 16'hffff, 30, 1'b0);

      // Short lifetimes relative to the step so entries expire often;
      // one phase runs the sender flat out.
      for (int p = 0; p < 4; p++)
         run_random_phase(TIME_W'($urandom_range(0, 6000)), TIME_W'($urandom_range(1, 2000)),
                          60, p == 1);

      await_idle();
      if (mismatch_count == 0)
         $display("route_discovery_table_core regression: pass");
      else
         $display("route_discovery_table_core regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/rdt_pkg.sv
design/rdt_cell.sv
design/route_discovery_table_core.sv
design/rdt_checker.sv
sim/tb_route_discovery_table_core.sv
